/* src/gcb_pkg.sv */
// shared types and constants of the grid cell bucket table
package gcb_pkg;

	// fixed field widths
	localparam int KIND_W   = 2;
	localparam int ID_W     = 10;
	localparam int POS_W    = 16;
	localparam int REQ_IX_W = 6;
	localparam int DIM_W    = 6;
	localparam int STATUS_W = 2;
	localparam int OUT_W    = 5;

	// configuration port
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd1;
	localparam logic [DIM_W-1:0] DIM_RESET = 6'd32;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_ADD_POS  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ADD_CELL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REMOVE   = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_PLACED   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_UNPLACED = 2'd3;

	// one result word
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [OUT_W-1:0]    col;
		logic [OUT_W-1:0]    row;
		logic [OUT_W-1:0]    slot;
	} res_t;

endpackage

/* src/gcb_ifs.sv */
// valid/ready channel interfaces for request, response and configuration
interface gcb_req_if;
	logic                                valid;
	logic                                ready;
	logic [gcb_pkg::KIND_W-1:0]          kind;
	logic [gcb_pkg::ID_W-1:0]            entity_id;
	logic signed [gcb_pkg::POS_W-1:0]    pos_x;
	logic signed [gcb_pkg::POS_W-1:0]    pos_y;
	logic [gcb_pkg::REQ_IX_W-1:0]        cell_col;
	logic [gcb_pkg::REQ_IX_W-1:0]        cell_row;

	modport source (output valid, kind, entity_id, pos_x, pos_y, cell_col, cell_row,
		input ready);
	modport sink (input valid, kind, entity_id, pos_x, pos_y, cell_col, cell_row,
		output ready);
endinterface

interface gcb_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [gcb_pkg::STATUS_W-1:0] status;
	logic [gcb_pkg::OUT_W-1:0]    out_col;
	logic [gcb_pkg::OUT_W-1:0]    out_row;
	logic [gcb_pkg::OUT_W-1:0]    out_slot;

	modport source (output valid, status, out_col, out_row, out_slot, input ready);
	modport sink (input valid, status, out_col, out_row, out_slot, output ready);
endinterface

interface gcb_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [gcb_pkg::CFG_IDX_W-1:0] index;
	logic [gcb_pkg::DIM_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* src/gcb_ram.sv */
// generic simple dual port ram with registered read
module gcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/gcb_locate.sv */
// two stage locator: position to cell, cell clamping and entity id wrap
module gcb_locate #(
	parameter int MAX_COLS     = 32,
	parameter int MAX_ROWS     = 32,
	parameter int MAX_ENTITIES = 1024,
	parameter int CELL_W       = 256,
	parameter int CELL_H       = 256,
	localparam int CW = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1,
	localparam int RW = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1,
	localparam int EW = $clog2(MAX_ENTITIES)
) (
	input  logic                              clk,
	input  logic [gcb_pkg::DIM_W-1:0]         grid_cols,
	input  logic [gcb_pkg::DIM_W-1:0]         grid_rows,
	input  logic [gcb_pkg::KIND_W-1:0]        kind,
	input  logic [gcb_pkg::ID_W-1:0]          entity_id,
	input  logic signed [gcb_pkg::POS_W-1:0]  pos_x,
	input  logic signed [gcb_pkg::POS_W-1:0]  pos_y,
	input  logic [gcb_pkg::REQ_IX_W-1:0]      cell_col,
	input  logic [gcb_pkg::REQ_IX_W-1:0]      cell_row,
	output logic [EW-1:0]                     eid,
	output logic [CW-1:0]                     col,
	output logic [RW-1:0]                     row
);

	localparam int CNW = $clog2(MAX_COLS + 1);
	localparam int RNW = $clog2(MAX_ROWS + 1);
	localparam int MAG_W = gcb_pkg::POS_W - 1;
	localparam int ID_W = gcb_pkg::ID_W;

	// reciprocal constants, exact for the numerator widths in use
	localparam int XL = $clog2(CELL_W);
	localparam int YL = $clog2(CELL_H);
	localparam int IL = $clog2(MAX_ENTITIES);
	localparam longint unsigned XM =
		((longint'(1) << (MAG_W + XL)) + longint'(CELL_W) - 1) / longint'(CELL_W);
	localparam longint unsigned YM =
		((longint'(1) << (MAG_W + YL)) + longint'(CELL_H) - 1) / longint'(CELL_H);
	localparam longint unsigned IM =
		((longint'(1) << (ID_W + IL)) + longint'(MAX_ENTITIES) - 1) / longint'(MAX_ENTITIES);
	localparam logic [16:0] XM17 = 17'(XM);
	localparam logic [16:0] YM17 = 17'(YM);
	localparam logic [16:0] IM17 = 17'(IM);
	localparam bit ID_WRAP = MAX_ENTITIES < (1 << ID_W);

	logic [31:0]           px_prod_s1, py_prod_s1;
	logic [26:0]           id_prod_s1;
	logic                  xneg_s1, yneg_s1, by_cell_s1;
	logic [ID_W-1:0]       id_s1;
	logic [gcb_pkg::REQ_IX_W-1:0] ccol_s1, crow_s1;

	logic [CNW-1:0]        cols_eff;
	logic [RNW-1:0]        rows_eff;
	logic [MAG_W-1:0]      qx, qy;
	logic [ID_W-1:0]       qid;
	logic [31:0]           id_rem;
	logic [MAG_W-1:0]      col_raw, row_raw;

	// stage 1: reciprocal products
	always_ff @(posedge clk) begin
		px_prod_s1  <= 32'(pos_x[MAG_W-1:0]) * 32'(XM17);
		py_prod_s1  <= 32'(pos_y[MAG_W-1:0]) * 32'(YM17);
		id_prod_s1  <= 27'(entity_id) * 27'(IM17);
		xneg_s1     <= pos_x[gcb_pkg::POS_W-1];
		yneg_s1     <= pos_y[gcb_pkg::POS_W-1];
		by_cell_s1  <= (kind == gcb_pkg::KIND_ADD_CELL);
		id_s1       <= entity_id;
		ccol_s1     <= cell_col;
		crow_s1     <= cell_row;
	end

	// grid size in use
	always_comb begin
		if (grid_cols == '0) begin
			cols_eff = CNW'(1);
		end else if (32'(grid_cols) > MAX_COLS) begin
			cols_eff = CNW'(MAX_COLS);
		end else begin
			cols_eff = CNW'(grid_cols);
		end
		if (grid_rows == '0) begin
			rows_eff = RNW'(1);
		end else if (32'(grid_rows) > MAX_ROWS) begin
			rows_eff = RNW'(MAX_ROWS);
		end else begin
			rows_eff = RNW'(grid_rows);
		end
	end

	// quotients and id remainder
	always_comb begin
		qx = xneg_s1 ? '0 : MAG_W'(px_prod_s1 >> (MAG_W + XL));
		qy = yneg_s1 ? '0 : MAG_W'(py_prod_s1 >> (MAG_W + YL));
		qid = ID_W'(id_prod_s1 >> (ID_W + IL));
		id_rem = 32'(id_s1) - 32'(qid) * 32'(MAX_ENTITIES);
		col_raw = by_cell_s1 ? MAG_W'(ccol_s1) : qx;
		row_raw = by_cell_s1 ? MAG_W'(crow_s1) : qy;
	end

	// stage 2: clamp into the grid
	always_ff @(posedge clk) begin
		eid <= ID_WRAP ? EW'(id_rem) : EW'(id_s1);
		if (32'(col_raw) >= 32'(cols_eff)) begin
			col <= CW'(cols_eff - CNW'(1));
		end else begin
			col <= CW'(col_raw);
		end
		if (32'(row_raw) >= 32'(rows_eff)) begin
			row <= RW'(rows_eff - RNW'(1));
		end else begin
			row <= RW'(row_raw);
		end
	end

endmodule

/* src/grid_cell_bucket_table_unit.sv */
// top level of the grid cell bucket table: sequencer, memories, result buffer
//
// Keeps a uniform grid of cells, each with a bounded list of entity ids, and a
// record per entity of its cell and slot. Requests arrive on the req channel
// (add by position, add at a cell, remove) and each gives exactly one word on
// the rsp channel with a status and the cell and slot affected. The grid size
// registers are written through the cfg channel, which is always ready; write
// them only while no request is in flight.
// One request is worked on at a time. An add passes through the locator, the
// entity record and cell count read and an evaluation of the result; a remove
// that moves the cell's last entry then reads its cell count and last slot.
// Pace is set by the chain of registered ram reads: entity record and cell
// count, then the count of the entity's cell, then the last slot entry.
// After reset a clearing pass zeroes the cell counts and entity records, one
// entry per cycle over max(cells, entities) entries (1024 at the default size);
// req stays not ready meanwhile. A finished word waits in a pending register
// while the output register is stalled; a new request is taken once the
// pending register has moved on.
module grid_cell_bucket_table_unit #(
	parameter int MAX_COLS      = 32,
	parameter int MAX_ROWS      = 32,
	parameter int CELL_CAPACITY = 32,
	parameter int MAX_ENTITIES  = 1024,
	parameter int CELL_W        = 256,
	parameter int CELL_H        = 256
) (
	input  logic  clk,
	input  logic  arst_n,
	gcb_cfg_if.sink   cfg,
	gcb_req_if.sink   req,
	gcb_rsp_if.source rsp
);

	localparam int CW  = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
	localparam int RW  = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
	localparam int SW  = CELL_CAPACITY > 1 ? $clog2(CELL_CAPACITY) : 1;
	localparam int NW  = $clog2(CELL_CAPACITY + 1);
	localparam int EW  = $clog2(MAX_ENTITIES);
	localparam int NUM_CELLS = MAX_COLS * MAX_ROWS;
	localparam int NUM_SLOTS = NUM_CELLS * CELL_CAPACITY;
	localparam int CLW = NUM_CELLS > 1 ? $clog2(NUM_CELLS) : 1;
	localparam int STW = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
	localparam int ERW = 1 + CW + RW + SW;
	localparam int CLR_N = NUM_CELLS > MAX_ENTITIES ? NUM_CELLS : MAX_ENTITIES;
	localparam int CLRW = $clog2(CLR_N);

	typedef enum logic [2:0] {
		S_IDLE, S_LOC1, S_LOC2, S_ERD, S_EVAL, S_RCNT, S_RLAST, S_RMOVE
	} state_t;

	state_t state_q;

	logic [gcb_pkg::DIM_W-1:0]        cols_q, rows_q;
	logic [gcb_pkg::KIND_W-1:0]       kind_q;
	logic [gcb_pkg::ID_W-1:0]         id_q;
	logic signed [gcb_pkg::POS_W-1:0] posx_q, posy_q;
	logic [gcb_pkg::REQ_IX_W-1:0]     ccol_q, crow_q;
	logic [CW-1:0]                    ecol_q;
	logic [RW-1:0]                    erow_q;
	logic [SW-1:0]                    eslot_q, last_q;
	logic                             clr_busy_q;
	logic [CLRW-1:0]                  clr_idx_q;
	logic                             pend_valid_q, out_valid_q;
	gcb_pkg::res_t                    pend_q, out_q;

	logic [EW-1:0] loc_eid;
	logic [CW-1:0] loc_col;
	logic [RW-1:0] loc_row;

	logic            cnt_we, cnt_re;
	logic [CLW-1:0]  cnt_waddr, cnt_raddr;
	logic [NW-1:0]   cnt_wdata, cnt_rdata;
	logic            ent_we, ent_re;
	logic [EW-1:0]   ent_waddr, ent_raddr;
	logic [ERW-1:0]  ent_wdata, ent_rdata;
	logic            slt_we, slt_re;
	logic [STW-1:0]  slt_waddr, slt_raddr;
	logic [EW-1:0]   slt_wdata, slt_rdata;

	logic            rd_placed;
	logic [CW-1:0]   rd_col;
	logic [RW-1:0]   rd_row;
	logic [SW-1:0]   rd_slot;
	logic [CLW-1:0]  add_cell, rm_cell;
	logic            add_full, rm_valid;
	logic            set_pend;
	logic            out_free;
	gcb_pkg::res_t   res;

	// configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= gcb_pkg::DIM_RESET;
			rows_q <= gcb_pkg::DIM_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				gcb_pkg::CFG_GRID_COLS: cols_q <= cfg.data;
				gcb_pkg::CFG_GRID_ROWS: rows_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// position and id locator
	gcb_locate #(
		.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .MAX_ENTITIES(MAX_ENTITIES),
		.CELL_W(CELL_W), .CELL_H(CELL_H)
	) u_locate (
		.clk(clk), .grid_cols(cols_q), .grid_rows(rows_q), .kind(kind_q),
		.entity_id(id_q), .pos_x(posx_q), .pos_y(posy_q), .cell_col(ccol_q),
		.cell_row(crow_q), .eid(loc_eid), .col(loc_col), .row(loc_row)
	);

	// memories
	gcb_ram #(.WIDTH(NW), .DEPTH(NUM_CELLS)) u_cnt_ram (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.re(cnt_re), .raddr(cnt_raddr), .rdata(cnt_rdata)
	);
	gcb_ram #(.WIDTH(ERW), .DEPTH(MAX_ENTITIES)) u_ent_ram (
		.clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
		.re(ent_re), .raddr(ent_raddr), .rdata(ent_rdata)
	);
	gcb_ram #(.WIDTH(EW), .DEPTH(NUM_SLOTS)) u_slot_ram (
		.clk(clk), .we(slt_we), .waddr(slt_waddr), .wdata(slt_wdata),
		.re(slt_re), .raddr(slt_raddr), .rdata(slt_rdata)
	);

	// entity record fields and cell numbers
	assign rd_placed = ent_rdata[ERW-1];
	assign rd_col    = ent_rdata[SW+RW+CW-1:SW+RW];
	assign rd_row    = ent_rdata[SW+RW-1:SW];
	assign rd_slot   = ent_rdata[SW-1:0];
	assign add_cell  = CLW'(32'(loc_col) * 32'(MAX_ROWS) + 32'(loc_row));
	assign rm_cell   = CLW'(32'(ecol_q) * 32'(MAX_ROWS) + 32'(erow_q));
	assign add_full  = 32'(cnt_rdata) >= 32'(CELL_CAPACITY);
	assign rm_valid  = (cnt_rdata != '0) && (32'(eslot_q) < 32'(cnt_rdata));

	// memory access and result selection per state
	always_comb begin
		cnt_we = 1'b0; cnt_re = 1'b0; cnt_waddr = add_cell; cnt_raddr = add_cell;
		cnt_wdata = cnt_rdata + NW'(1);
		ent_we = 1'b0; ent_re = 1'b0; ent_waddr = loc_eid; ent_raddr = loc_eid;
		ent_wdata = {1'b1, loc_col, loc_row, SW'(cnt_rdata)};
		slt_we = 1'b0; slt_re = 1'b0;
		slt_waddr = STW'(32'(add_cell) * 32'(CELL_CAPACITY) + 32'(cnt_rdata));
		slt_raddr = STW'(32'(rm_cell) * 32'(CELL_CAPACITY) + 32'(cnt_rdata - NW'(1)));
		slt_wdata = loc_eid;
		set_pend = 1'b0;
		res = '{status: gcb_pkg::ST_OK, col: '0, row: '0, slot: '0};
		if (clr_busy_q) begin
			cnt_we    = 32'(clr_idx_q) < NUM_CELLS;
			cnt_waddr = CLW'(clr_idx_q);
			cnt_wdata = '0;
			ent_we    = 32'(clr_idx_q) < MAX_ENTITIES;
			ent_waddr = EW'(clr_idx_q);
			ent_wdata = '0;
		end else begin
			unique case (state_q)
				S_ERD: begin
					ent_re = 1'b1;
					cnt_re = 1'b1;
				end
				S_EVAL: begin
					set_pend = 1'b1;
					case (kind_q) inside
						gcb_pkg::KIND_ADD_POS, gcb_pkg::KIND_ADD_CELL: begin
							if (rd_placed) begin
								res = '{status: gcb_pkg::ST_PLACED, col: 5'(rd_col),
									row: 5'(rd_row), slot: 5'(rd_slot)};
							end else if (add_full) begin
								res = '{status: gcb_pkg::ST_FULL, col: 5'(loc_col),
									row: 5'(loc_row), slot: '0};
							end else begin
								cnt_we = 1'b1;
								ent_we = 1'b1;
								slt_we = 1'b1;
								res = '{status: gcb_pkg::ST_OK, col: 5'(loc_col),
									row: 5'(loc_row), slot: 5'(cnt_rdata)};
							end
						end
						gcb_pkg::KIND_REMOVE: begin
							if (rd_placed) begin
								set_pend = 1'b0;
							end else begin
								res = '{status: gcb_pkg::ST_UNPLACED, col: '0,
									row: '0, slot: '0};
							end
						end
						default: ;
					endcase
				end
				S_RCNT: begin
					cnt_re    = 1'b1;
					cnt_raddr = rm_cell;
				end
				S_RLAST: begin
					// clear the placed mark of the removed entity
					ent_we    = 1'b1;
					ent_wdata = {1'b0, ecol_q, erow_q, eslot_q};
					if (rm_valid) begin
						slt_re    = 1'b1;
						cnt_we    = 1'b1;
						cnt_waddr = rm_cell;
						cnt_wdata = cnt_rdata - NW'(1);
					end else begin
						set_pend = 1'b1;
					end
					res = '{status: gcb_pkg::ST_OK, col: 5'(ecol_q), row: 5'(erow_q),
						slot: 5'(eslot_q)};
				end
				S_RMOVE: begin
					// last entry fills the freed slot
					slt_we    = 1'b1;
					slt_waddr = STW'(32'(rm_cell) * 32'(CELL_CAPACITY) + 32'(eslot_q));
					slt_wdata = slt_rdata;
					ent_we    = eslot_q < last_q;
					ent_waddr = slt_rdata;
					ent_wdata = {1'b1, ecol_q, erow_q, eslot_q};
					set_pend  = 1'b1;
					res = '{status: gcb_pkg::ST_OK, col: 5'(ecol_q), row: 5'(erow_q),
						slot: 5'(eslot_q)};
				end
				default: ;
			endcase
		end
	end

	// request channel
	assign req.ready = (state_q == S_IDLE) && !clr_busy_q && !pend_valid_q;

	// response channel
	assign rsp.valid    = out_valid_q;
	assign rsp.status   = out_q.status;
	assign rsp.out_col  = out_q.col;
	assign rsp.out_row  = out_q.row;
	assign rsp.out_slot = out_q.slot;

	// output register can take the pending word
	assign out_free = !out_valid_q || rsp.ready;

	// sequencer, clearing pass and result buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			clr_busy_q   <= 1'b1;
			clr_idx_q    <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + CLRW'(1);
				if (32'(clr_idx_q) == CLR_N - 1) begin
					clr_busy_q <= 1'b0;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						kind_q  <= req.kind;
						id_q    <= req.entity_id;
						posx_q  <= req.pos_x;
						posy_q  <= req.pos_y;
						ccol_q  <= req.cell_col;
						crow_q  <= req.cell_row;
						state_q <= S_LOC1;
					end
				end
				S_LOC1: state_q <= S_LOC2;
				S_LOC2: state_q <= S_ERD;
				S_ERD:  state_q <= S_EVAL;
				S_EVAL: begin
					ecol_q  <= rd_col;
					erow_q  <= rd_row;
					eslot_q <= rd_slot;
					if (kind_q == gcb_pkg::KIND_REMOVE && rd_placed) begin
						state_q <= S_RCNT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_RCNT: state_q <= S_RLAST;
				S_RLAST: begin
					last_q  <= SW'(cnt_rdata - NW'(1));
					state_q <= rm_valid ? S_RMOVE : S_IDLE;
				end
				S_RMOVE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			// pending word moves to the output register when it is free
			if (out_free) begin
				out_valid_q <= pend_valid_q;
				out_q       <= pend_q;
			end
			if (set_pend) begin
				pend_valid_q <= 1'b1;
				pend_q       <= res;
			end else if (out_free) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* tb/sv/tb.sv */
// testbench for the grid cell bucket table: directed table, random phases, scoreboard
`timescale 1ns / 100ps

module tb;
	import gcb_pkg::*;

	// block sizes, matching the default parameters of the unit
	localparam int N_COLS      = 32;
	localparam int N_ROWS      = 32;
	localparam int CAPACITY    = 32;
	localparam int N_ENT       = 1024;
	localparam int CELL_SIZE_X = 256;
	localparam int CELL_SIZE_Y = 256;

	// the one kind code the package leaves unnamed: does nothing
	localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

	// stretch of items and words with no idling on either side
	localparam int QUIET_LO = 400;
	localparam int QUIET_HI = 550;

	typedef struct packed {
		logic [KIND_W-1:0]          kind;
		logic [ID_W-1:0]            entity_id;
		logic signed [POS_W-1:0]    pos_x;
		logic signed [POS_W-1:0]    pos_y;
		logic [REQ_IX_W-1:0]        cell_col;
		logic [REQ_IX_W-1:0]        cell_row;
	} bucket_req_t;

	typedef struct packed {
		bucket_req_t req;
		bit          typed;
		res_t        want;
	} dir_row_t;

	localparam res_t NO_RES = '0;

	logic clk;
	logic arst_n;

	gcb_cfg_if cfg_ch();
	gcb_req_if req_ch();
	gcb_rsp_if rsp_ch();

	grid_cell_bucket_table_unit #(
		.MAX_COLS(N_COLS),
		.MAX_ROWS(N_ROWS),
		.CELL_CAPACITY(CAPACITY),
		.MAX_ENTITIES(N_ENT),
		.CELL_W(CELL_SIZE_X),
		.CELL_H(CELL_SIZE_Y)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// shadow copy of the grid state
	logic [ID_W-1:0] slot_q [N_COLS*N_ROWS*CAPACITY];
	int unsigned     cell_count_q [N_COLS*N_ROWS];
	bit              placed_q [N_ENT];
	int unsigned     ent_cell_q [N_ENT];
	int unsigned     ent_slot_q [N_ENT];
	logic [DIM_W-1:0] grid_cols_q = DIM_RESET;
	logic [DIM_W-1:0] grid_rows_q = DIM_RESET;

	// words the block still owes, oldest first
	res_t bucket_results_due [$];

	int unsigned mismatch_count = 0;
	int unsigned sent_count = 0;
	int unsigned results_seen = 0;
	int unsigned pool_size = 64;
	int unsigned add_pct = 55;

	// directed rows, grid at its reset size of 32 x 32
	dir_row_t dir_rows [0:19] = '{
		'{'{KIND_ADD_POS,  10'd0,    16'sh0000, 16'sh0000, 6'd0,  6'd0},  1'b1,
			'{ST_OK, 5'd0, 5'd0, 5'd0}},
		'{'{KIND_ADD_POS,  10'd1023, 16'sh7FFF, 16'sh7FFF, 6'd0,  6'd0},  1'b1,
			'{ST_OK, 5'd31, 5'd31, 5'd0}},
		'{'{KIND_ADD_POS,  10'd1,    16'sh8000, 16'shFFFF, 6'd63, 6'd63}, 1'b1,
			'{ST_OK, 5'd0, 5'd0, 5'd1}},
		'{'{KIND_ADD_POS,  10'd0,    16'sh0064, 16'sh0064, 6'd0,  6'd0},  1'b1,
			'{ST_PLACED, 5'd0, 5'd0, 5'd0}},
		'{'{KIND_REMOVE,   10'd5,    16'sh0000, 16'sh0000, 6'd0,  6'd0},  1'b1,
			'{ST_UNPLACED, 5'd0, 5'd0, 5'd0}},
		'{'{KIND_NOP,      10'd7,    16'shFFFF, 16'sh1234, 6'd9,  6'd4},  1'b1,
			'{ST_OK, 5'd0, 5'd0, 5'd0}},
		'{'{KIND_ADD_CELL, 10'd2,    16'sh0000, 16'sh0000, 6'd63, 6'd63}, 1'b1,
			'{ST_OK, 5'd31, 5'd31, 5'd1}},
		'{'{KIND_ADD_CELL, 10'd3,    16'sh7FFF, 16'sh7FFF, 6'd0,  6'd0},  1'b1,
			'{ST_OK, 5'd0, 5'd0, 5'd2}},
		'{'{KIND_ADD_POS,  10'd4,    16'sh00FF, 16'sh0100, 6'd0,  6'd0},  1'b0, NO_RES},
		'{'{KIND_ADD_POS,  10'd6,    16'sh1FFF, 16'shFFFB, 6'd0,  6'd0},  1'b0, NO_RES},
		'{'{KIND_ADD_CELL, 10'd8,    16'sh0000, 16'sh0000, 6'd31, 6'd0},  1'b0, NO_RES},
		'{'{KIND_REMOVE,   10'd0,    16'sh0000, 16'sh0000, 6'd0,  6'd0},  1'b1,
			'{ST_OK, 5'd0, 5'd0, 5'd0}},
		'{'{KIND_REMOVE,   10'd0,    16'sh0000, 16'sh0000, 6'd0,  6'd0},  1'b1,
			'{ST_UNPLACED, 5'd0, 5'd0, 5'd0}},
		'{'{KIND_REMOVE,   10'd1,    16'sh0000, 16'sh0000, 6'd0,  6'd0},  1'b0, NO_RES},
		'{'{KIND_ADD_CELL, 10'd1023, 16'sh0000, 16'sh0000, 6'd0,  6'd0},  1'b1,
			'{ST_PLACED, 5'd31, 5'd31, 5'd0}},
		'{'{KIND_REMOVE,   10'd2,    16'sh0000, 16'sh0000, 6'd0,  6'd0},  1'b0, NO_RES},
		'{'{KIND_REMOVE,   10'd3,    16'sh0000, 16'sh0000, 6'd0,  6'd0},  1'b0, NO_RES},
		'{'{KIND_ADD_POS,  10'd512,  16'sh7FFF, 16'sh0000, 6'd0,  6'd0},  1'b0, NO_RES},
		'{'{KIND_NOP,      10'd1023, 16'shFFFF, 16'shFFFF, 6'd63, 6'd63}, 1'b1,
			'{ST_OK, 5'd0, 5'd0, 5'd0}},
		'{'{KIND_REMOVE,   10'd1023, 16'sh0000, 16'sh0000, 6'd0,  6'd0},  1'b1,
			'{ST_OK, 5'd31, 5'd31, 5'd0}}
	};

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// grid size in use: zero acts as one, anything above the maximum as the maximum
	function automatic int unsigned eff_dim(logic [DIM_W-1:0] v, int unsigned maxv);
		if (v == 0)
			return 1;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	// world coordinate to cell index, negative to zero, clamped to the grid
	function automatic int unsigned axis_index(logic signed [POS_W-1:0] p, int size,
		int unsigned n);
		int pv;
		int unsigned ix;
		pv = p;
		ix = (pv < 0) ? 0 : pv / size;
		return (ix >= n) ? n - 1 : ix;
	endfunction

	// predicts the word for one request and updates the shadow grid
	function automatic res_t predict_bucket_op(bucket_req_t r);
		res_t o;
		int unsigned id, cols, rows, col, row, cix, cnt, slot, last, moved;
		o = '0;
		id = r.entity_id;
		cols = eff_dim(grid_cols_q, N_COLS);
		rows = eff_dim(grid_rows_q, N_ROWS);
		if (r.kind == KIND_ADD_POS || r.kind == KIND_ADD_CELL) begin
			// already placed: report where it sits
			if (placed_q[id]) begin
				cix = ent_cell_q[id];
				o = '{ST_PLACED, 5'(cix / N_ROWS), 5'(cix % N_ROWS), 5'(ent_slot_q[id])};
				return o;
			end
			if (r.kind == KIND_ADD_POS) begin
				col = axis_index(r.pos_x, CELL_SIZE_X, cols);
				row = axis_index(r.pos_y, CELL_SIZE_Y, rows);
			end else begin
				col = (r.cell_col >= cols) ? cols - 1 : r.cell_col;
				row = (r.cell_row >= rows) ? rows - 1 : r.cell_row;
			end
			cix = col * N_ROWS + row;
			cnt = cell_count_q[cix];
			if (cnt >= CAPACITY) begin
				o = '{ST_FULL, 5'(col), 5'(row), 5'd0};
				return o;
			end
			// append to the end of the cell's list
			slot_q[cix * CAPACITY + cnt] = r.entity_id;
			cell_count_q[cix] = cnt + 1;
			placed_q[id] = 1'b1;
			ent_cell_q[id] = cix;
			ent_slot_q[id] = cnt;
			o = '{ST_OK, 5'(col), 5'(row), 5'(cnt)};
		end else if (r.kind == KIND_REMOVE) begin
			if (!placed_q[id]) begin
				o = '{ST_UNPLACED, 5'd0, 5'd0, 5'd0};
				return o;
			end
			cix = ent_cell_q[id];
			cnt = cell_count_q[cix];
			slot = ent_slot_q[id];
			// last entry moves into the freed slot
			if (cnt > 0 && slot < cnt) begin
				last = cnt - 1;
				moved = slot_q[cix * CAPACITY + last];
				slot_q[cix * CAPACITY + slot] = ID_W'(moved);
				if (slot < last)
					ent_slot_q[moved] = slot;
				cell_count_q[cix] = last;
			end
			placed_q[id] = 1'b0;
			o = '{ST_OK, 5'(cix / N_ROWS), 5'(cix % N_ROWS), 5'(slot)};
		end
		return o;
	endfunction

	// random request: mostly adds and removes over a small id pool
	function automatic bucket_req_t rand_bucket_req();
		bucket_req_t r;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < add_pct)
			r.kind = ($urandom_range(1) != 0) ? KIND_ADD_POS : KIND_ADD_CELL;
		else if (pick < 96)
			r.kind = KIND_REMOVE;
		else
			r.kind = KIND_NOP;
		r.entity_id = ($urandom_range(9) == 0) ? ID_W'($urandom)
			: ID_W'($urandom_range(pool_size - 1));
		case ($urandom_range(3))
			0: begin
				r.pos_x = POS_W'($urandom);
				r.pos_y = POS_W'($urandom);
			end
			3: begin
				r.pos_x = POS_W'($urandom_range(32'h8000, 32'hFFFF));
				r.pos_y = POS_W'($urandom_range(8447));
			end
			default: begin
				r.pos_x = POS_W'($urandom_range(8447));
				r.pos_y = ($urandom_range(7) == 0)
					? POS_W'($urandom_range(32'h8000, 32'hFFFF))
					: POS_W'($urandom_range(8447));
			end
		endcase
		if ($urandom_range(1) != 0) begin
			r.cell_col = REQ_IX_W'($urandom);
			r.cell_row = REQ_IX_W'($urandom);
		end else begin
			r.cell_col = REQ_IX_W'($urandom_range(33));
			r.cell_row = REQ_IX_W'($urandom_range(33));
		end
		return r;
	endfunction

	// one line per bad word
	task automatic report_mismatch(string what, res_t got, res_t want);
		mismatch_count++;
		$display("tb: mismatch (%s) at %0t: got %0d/%0d/%0d/%0d want %0d/%0d/%0d/%0d",
			what, $time, got.status, got.col, got.row, got.slot,
			want.status, want.col, want.row, want.slot);
	endtask

	// offer one request word until it is taken, then log what it should give
	task automatic offer_request(bucket_req_t r, bit typed, res_t want);
		res_t predicted;
		if (!(sent_count >= QUIET_LO && sent_count < QUIET_HI) && $urandom_range(99) < 16) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.kind      <= r.kind;
		req_ch.entity_id <= r.entity_id;
		req_ch.pos_x     <= r.pos_x;
		req_ch.pos_y     <= r.pos_y;
		req_ch.cell_col  <= r.cell_col;
		req_ch.cell_row  <= r.cell_row;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		predicted = predict_bucket_op(r);
		bucket_results_due.push_back(typed ? want : predicted);
		sent_count++;
	endtask

	// write one grid register; valid is lowered by the caller
	task automatic write_grid_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		if (idx == CFG_GRID_COLS)
			grid_cols_q = val;
		else
			grid_rows_q = val;
	endtask

	// wait for every owed word, then let the sequencer settle
	task automatic drain_results();
		while (bucket_results_due.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// new grid size, then a run of random requests
	task automatic run_phase(logic [DIM_W-1:0] cols, logic [DIM_W-1:0] rows, int n,
		int unsigned pool, int unsigned adds);
		drain_results();
		write_grid_reg(CFG_GRID_COLS, cols);
		write_grid_reg(CFG_GRID_ROWS, rows);
		cfg_ch.valid <= 1'b0;
		pool_size = pool;
		add_pct = adds;
		repeat (n) offer_request(rand_bucket_req(), 1'b0, NO_RES);
		req_ch.valid <= 1'b0;
	endtask

	// reset and request side
	initial begin : stimulus
		arst_n           <= 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.kind      <= KIND_ADD_POS;
		req_ch.entity_id <= '0;
		req_ch.pos_x     <= '0;
		req_ch.pos_y     <= '0;
		req_ch.cell_col  <= '0;
		req_ch.cell_row  <= '0;
		cfg_ch.valid     <= 1'b0;
		cfg_ch.index     <= CFG_GRID_COLS;
		cfg_ch.data      <= DIM_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed rows at the reset grid size
		foreach (dir_rows[i])
			offer_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
		req_ch.valid <= 1'b0;

		// single cell fills up, then sizes out of range, then ordinary grids and a random size
		run_phase(6'd1, 6'd1, 180, 48, 70);
		run_phase(6'd0, 6'd63, 150, 80, 60);
		run_phase(6'd63, 6'd0, 150, 80, 60);
		run_phase(6'd3, 6'd5, 250, 200, 55);
		run_phase(6'd32, 6'd32, 250, 600, 55);
		run_phase(DIM_W'($urandom_range(63)), DIM_W'($urandom_range(63)), 150, 300, 55);

		drain_results();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

	// result side: random stalls, two long hold-offs, scoreboard
	initial begin : result_side
		res_t got, want;
		int unsigned hold_left;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				got = '{rsp_ch.status, rsp_ch.out_col, rsp_ch.out_row, rsp_ch.out_slot};
				results_seen++;
				if (bucket_results_due.size() == 0) begin
					report_mismatch("word with nothing due", got, NO_RES);
				end else begin
					want = bucket_results_due.pop_front();
					if (got.status !== want.status || got.col !== want.col
						|| got.row !== want.row || got.slot !== want.slot)
						report_mismatch("field", got, want);
				end
				// hold off long enough for the block to back up into its input
				if (results_seen == 150 || results_seen == 700)
					hold_left = 250;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (results_seen >= QUIET_LO && results_seen < QUIET_HI) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= 16);
			end
		end
	end

	// run limit
	initial begin : watchdog
		#2000000;
		$display("tb: errors");
		$finish;
	end

endmodule
